// File: src/bcdrtc_pkg.sv
// Shared types and constants for the BCD clock battery RAM.
package bcdrtc_pkg;

   localparam int STORE_BYTES_DEF = 8192;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   localparam logic [2:0] OFS_CENTURY = 3'd0;
   localparam logic [2:0] OFS_SECOND  = 3'd1;
   localparam logic [2:0] OFS_MINUTE  = 3'd2;
   localparam logic [2:0] OFS_HOUR    = 3'd3;
   localparam logic [2:0] OFS_WEEKDAY = 3'd4;
   localparam logic [2:0] OFS_DAY     = 3'd5;
   localparam logic [2:0] OFS_MONTH   = 3'd6;
   localparam logic [2:0] OFS_YEAR    = 3'd7;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [11:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [2:0]  load_weekday;
      logic [4:0]  load_hour;
      logic [5:0]  load_minute;
      logic [5:0]  load_second;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clock_read_seen;
      logic       clock_write_seen;
   } rsp_type;

   typedef struct packed {
      logic       rd;
      logic       wr;
      logic       load;
      logic [2:0] offset;
   } clk_cmd_type;

   typedef struct packed {
      logic [12:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  weekday;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
   } clk_time_type;

   typedef logic [7:0][7:0] clk_bytes_type;

   localparam clk_time_type RST_TIME = '{
      year: 13'd2000, month: 7'd1, day: 7'd1, weekday: 7'd1,
      hour: 7'd0, minute: 7'd0, second: 7'd0
   };

endpackage

// File: src/bcd_rtc_nvram_bus_model_unit.sv
// Top level of the BCD clock battery RAM bus model.
//
// Requests arrive on req_valid/req_ready with one req_type payload each:
// a bus read, a bus write, a load of the binary clock, or a no-op code.
// Every request gives exactly one response on rsp_valid/rsp_ready.
// The top eight bytes of the store are clock registers held in flops;
// the rest lives in a RAM with a registered read.
// A read of the RAM area goes by way of ST_READ: address to the RAM in the
// accept cycle, response registered in the next. Every other request
// completes in its accept cycle, with the response valid in the next cycle,
// so those run at one request per cycle while the receiver takes each response.
// The response register frees the input side: a request is taken while
// the previous response is being handed over. If the receiver stalls,
// the response is held and no further request is taken.
// After reset the RAM is swept to zero, one byte a cycle, over all
// STORE_BYTES addresses with req_ready low; the clock comes up at
// 2000-01-01 00:00:00, weekday 1, and is copied into the clock bytes.
module bcd_rtc_nvram_bus_model_unit #(
   parameter int STORE_BYTES = bcdrtc_pkg::STORE_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bcdrtc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bcdrtc_pkg::rsp_type rsp_data
);
   import bcdrtc_pkg::*;

   localparam int ADDR_W   = $clog2(STORE_BYTES);
   localparam int CLK_BASE = STORE_BYTES - 8;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clear_ff, clear_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept, in_range, is_clk, ram_read;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata, ram_rdata;
   clk_cmd_type       cmd;
   logic [7:0]        clk_byte;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign in_range  = {1'b0, req_data.address} < 17'(STORE_BYTES);
   assign is_clk    = in_range && ({1'b0, req_data.address} >= 17'(CLK_BASE));
   assign ram_read  = (req_data.opcode == OP_READ) && in_range && !is_clk;

   always_comb begin
      cmd.rd     = accept && (req_data.opcode == OP_READ) && is_clk;
      cmd.wr     = accept && (req_data.opcode == OP_WRITE) && is_clk;
      cmd.load   = accept && (req_data.opcode == OP_LOAD);
      cmd.offset = 3'(req_data.address - 16'(CLK_BASE));
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clear_ff;
         ram_wdata = 8'h00;
      end else begin
         ram_we    = accept && (req_data.opcode == OP_WRITE) && in_range && !is_clk;
         ram_waddr = req_data.address[ADDR_W-1:0];
         ram_wdata = req_data.write_data;
      end
   end

   bcdrtc_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept && ram_read),
      .rd_addr (req_data.address[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   bcdrtc_clock u_clock (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req     (req_data),
      .rd_byte (clk_byte)
   );

   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + ADDR_W'(1);
            if (clear_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (ram_read) begin
                  state_in = ST_READ;
               end else begin
                  rsp_in.read_data        = cmd.rd ? clk_byte : 8'h00;
                  rsp_in.clock_read_seen  = cmd.rd;
                  rsp_in.clock_write_seen = cmd.wr;
                  rsp_valid_in            = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_in.read_data        = ram_rdata;
            rsp_in.clock_read_seen  = 1'b0;
            rsp_in.clock_write_seen = 1'b0;
            rsp_valid_in            = 1'b1;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("response valid during RAM sweep");

   a_ram_read_waits: assert property (@(posedge clock) disable iff (reset)
      accept && ram_read |=> state_ff == ST_READ && !rsp_valid_ff)
      else $error("RAM read did not enter read wait with empty response slot");

   a_read_completes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("RAM read gave no response");

   a_direct_completes: assert property (@(posedge clock) disable iff (reset)
      accept && !ram_read |=> rsp_valid_ff)
      else $error("request gave no response");

endmodule

// File: src/bcdrtc_ram.sv
// Generic simple dual-port RAM with registered read.
module bcdrtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: src/bcdrtc_clock.sv
// Binary clock, BCD clock register bytes and their copy and decode logic.
module bcdrtc_clock (
   input  logic                     clock,
   input  logic                     reset,
   input  bcdrtc_pkg::clk_cmd_type  cmd,
   input  bcdrtc_pkg::req_type      req,
   output logic [7:0]               rd_byte
);
   import bcdrtc_pkg::*;

   localparam logic [7:0] BIT_BF = 8'h80;

   clk_bytes_type bytes_ff, bytes_in;
   clk_time_type  time_ff, time_in;
   clk_bytes_type wb, enc;
   clk_time_type  load_time, t_src;
   logic          refresh;
   logic [7:0]    old_cent;

   function automatic logic [7:0] to_bcd7(input logic [6:0] v);
      logic [6:0]  m;
      logic [14:0] p;
      logic [3:0]  t;
      logic [6:0]  o;
      m = (v >= 7'd100) ? v - 7'd100 : v;
      p = 15'(m) * 15'd205;
      t = p[14:11];
      o = m - 7'(t) * 7'd10;
      return {t, o[3:0]};
   endfunction

   function automatic logic [15:0] year_bcd(input logic [12:0] y);
      logic [25:0] p;
      logic [6:0]  q;
      logic [12:0] r;
      p = 26'(y) * 26'd5243;
      q = p[25:19];
      r = y - 13'(q) * 13'd100;
      return {to_bcd7(q), to_bcd7(r[6:0])};
   endfunction

   function automatic logic [7:0] from_bcd(input logic [7:0] v);
      logic [7:0] w;
      w = v;
      if (w[3:0] > 4'd9) begin
         w = w + 8'h06;
      end
      if (w[7:4] > 4'd9) begin
         w = w + 8'h60;
      end
      return 8'(w[3:0]) + 8'(w[7:4]) * 8'd10;
   endfunction

   function automatic clk_bytes_type clock_to_bytes(input clk_bytes_type b,
                                                    input clk_time_type t);
      clk_bytes_type r;
      logic [15:0]   yb;
      yb = year_bcd(t.year);
      r = b;
      r[OFS_CENTURY] = (b[OFS_CENTURY] & 8'hc0) | (yb[15:8] & 8'h3f);
      r[OFS_YEAR]    = yb[7:0];
      r[OFS_MONTH]   = (b[OFS_MONTH] & 8'he0) | (to_bcd7(t.month) & 8'h1f);
      r[OFS_DAY]     = (b[OFS_DAY] & 8'hc0) | (to_bcd7(t.day) & 8'h3f);
      r[OFS_WEEKDAY] = (b[OFS_WEEKDAY] & 8'hf8) | (to_bcd7(t.weekday) & 8'h07);
      r[OFS_HOUR]    = (b[OFS_HOUR] & 8'hc0) | (to_bcd7(t.hour) & 8'h3f);
      r[OFS_MINUTE]  = (b[OFS_MINUTE] & 8'h80) | (to_bcd7(t.minute) & 8'h7f);
      r[OFS_SECOND]  = (b[OFS_SECOND] & 8'h80) | (to_bcd7(t.second) & 8'h7f);
      return r;
   endfunction

   function automatic clk_time_type bytes_to_clock(input clk_bytes_type b);
      clk_time_type t;
      logic [7:0]   v;
      t.year    = 13'(16'(from_bcd(b[OFS_CENTURY] & 8'h3f)) * 16'd100
                      + 16'(from_bcd(b[OFS_YEAR])));
      v = from_bcd(b[OFS_MONTH] & 8'h1f);
      t.month   = v[6:0];
      v = from_bcd(b[OFS_DAY] & 8'h3f);
      t.day     = v[6:0];
      v = from_bcd(b[OFS_WEEKDAY] & 8'h07);
      t.weekday = v[6:0];
      v = from_bcd(b[OFS_HOUR] & 8'h3f);
      t.hour    = v[6:0];
      v = from_bcd(b[OFS_MINUTE] & 8'h7f);
      t.minute  = v[6:0];
      v = from_bcd(b[OFS_SECOND] & 8'h7f);
      t.second  = v[6:0];
      return t;
   endfunction

   always_comb begin
      load_time.year    = 13'(req.load_year);
      load_time.month   = 7'(req.load_month) + 7'd1;
      load_time.day     = 7'(req.load_day) + 7'd1;
      load_time.weekday = 7'(req.load_weekday) + 7'd1;
      load_time.hour    = 7'(req.load_hour);
      load_time.minute  = 7'(req.load_minute);
      load_time.second  = 7'(req.load_second);
   end

   always_comb begin
      wb = bytes_ff;
      if (cmd.wr) begin
         wb[cmd.offset] = req.write_data;
      end
      t_src    = cmd.load ? load_time : time_ff;
      enc      = clock_to_bytes(wb, t_src);
      old_cent = bytes_ff[OFS_CENTURY];
      refresh  = (old_cent[7:6] == 2'b00);
      bytes_in = bytes_ff;
      time_in  = time_ff;
      if (cmd.rd && refresh) begin
         bytes_in = enc;
      end
      if (cmd.wr) begin
         bytes_in = wb;
         if (cmd.offset == OFS_CENTURY) begin
            if (old_cent[6] != req.write_data[6]) begin
               bytes_in = enc;
            end else if (old_cent[7] && !req.write_data[7]) begin
               time_in = bytes_to_clock(wb);
            end
         end
      end
      if (cmd.load) begin
         time_in  = load_time;
         bytes_in = enc;
      end
      rd_byte = bytes_in[cmd.offset];
      if (cmd.offset == OFS_WEEKDAY) begin
         rd_byte = rd_byte | BIT_BF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= clock_to_bytes('0, RST_TIME);
         time_ff  <= RST_TIME;
      end else if (cmd.rd || cmd.wr || cmd.load) begin
         bytes_ff <= bytes_in;
         time_ff  <= time_in;
      end
   end

endmodule

// File: verif/bcd_rtc_nvram_bus_model_unit_check.sv
// Checker for the BCD clock battery RAM: mirrors the store and clock, checks every response.
`timescale 1ns / 100ps

module bcd_rtc_nvram_bus_model_unit_check (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  bcdrtc_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  bcdrtc_pkg::rsp_type rsp_data,
   output int                  mismatches,
   output int                  replies_owed
);

   import bcdrtc_pkg::*;

   localparam int RTC_BASE = STORE_BYTES_DEF - 8;
   localparam logic [7:0] CTL_W   = 8'h80;
   localparam logic [7:0] CTL_R   = 8'h40;
   localparam logic [7:0] FLAG_BF = 8'h80;

   logic [7:0]   nvram_bytes [STORE_BYTES_DEF];
   clk_time_type rtc_time;
   rsp_type      replies_due [$];
   int           fails = 0;

   function automatic logic [7:0] bin_to_bcd(input int unsigned v);
      int unsigned m;
      m = v % 100;
      return 8'(((m / 10) << 4) | (m % 10));
   endfunction

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      int unsigned v;
      v = b;
      if ((v & 'h0f) > 'h09) v += 'h06;
      if ((v & 'hf0) > 'h90) v += 'h60;
      return 8'((v & 'h0f) + 10 * ((v >> 4) & 'h0f));
   endfunction

   function automatic void merge_clock_byte(input logic [2:0] ofs, input logic [7:0] keep,
                                            input logic [7:0] val);
      int a;
      a = RTC_BASE + int'(ofs);
      nvram_bytes[a] = (nvram_bytes[a] & keep) | (val & ~keep);
   endfunction

   function automatic void time_to_bytes();
      merge_clock_byte(OFS_CENTURY, 8'hc0, bin_to_bcd(rtc_time.year / 100));
      merge_clock_byte(OFS_YEAR,    8'h00, bin_to_bcd(rtc_time.year % 100));
      merge_clock_byte(OFS_MONTH,   8'he0, bin_to_bcd(rtc_time.month));
      merge_clock_byte(OFS_DAY,     8'hc0, bin_to_bcd(rtc_time.day));
      merge_clock_byte(OFS_WEEKDAY, 8'hf8, bin_to_bcd(rtc_time.weekday));
      merge_clock_byte(OFS_HOUR,    8'hc0, bin_to_bcd(rtc_time.hour));
      merge_clock_byte(OFS_MINUTE,  8'h80, bin_to_bcd(rtc_time.minute));
      merge_clock_byte(OFS_SECOND,  8'h80, bin_to_bcd(rtc_time.second));
   endfunction

   function automatic logic [7:0] clock_byte(input logic [2:0] ofs);
      return nvram_bytes[RTC_BASE + int'(ofs)];
   endfunction

   function automatic void bytes_to_time();
      rtc_time.year    = 13'(100 * int'(bcd_to_bin(clock_byte(OFS_CENTURY) & 8'h3f))
                             + int'(bcd_to_bin(clock_byte(OFS_YEAR))));
      rtc_time.month   = 7'(bcd_to_bin(clock_byte(OFS_MONTH) & 8'h1f));
      rtc_time.day     = 7'(bcd_to_bin(clock_byte(OFS_DAY) & 8'h3f));
      rtc_time.weekday = 7'(bcd_to_bin(clock_byte(OFS_WEEKDAY) & 8'h07));
      rtc_time.hour    = 7'(bcd_to_bin(clock_byte(OFS_HOUR) & 8'h3f));
      rtc_time.minute  = 7'(bcd_to_bin(clock_byte(OFS_MINUTE) & 8'h7f));
      rtc_time.second  = 7'(bcd_to_bin(clock_byte(OFS_SECOND) & 8'h7f));
   endfunction

   function automatic rsp_type bus_access_result(input req_type r);
      rsp_type    o;
      int         a;
      logic [7:0] diff;
      o = '0;
      a = int'(r.address);
      case (r.opcode)
         OP_READ: begin
            if (a < STORE_BYTES_DEF) begin
               if (a >= RTC_BASE) begin
                  o.clock_read_seen = 1'b1;
                  if ((clock_byte(OFS_CENTURY) & (CTL_R | CTL_W)) == 8'h00) time_to_bytes();
                  o.read_data = nvram_bytes[a];
                  if (a == RTC_BASE + int'(OFS_WEEKDAY)) o.read_data |= FLAG_BF;
               end else begin
                  o.read_data = nvram_bytes[a];
               end
            end
         end
         OP_WRITE: begin
            if (a < STORE_BYTES_DEF) begin
               if (a >= RTC_BASE) o.clock_write_seen = 1'b1;
               if (a == RTC_BASE + int'(OFS_CENTURY)) begin
                  diff = nvram_bytes[a] ^ r.write_data;
                  nvram_bytes[a] = r.write_data;
                  if ((diff & CTL_R) != 8'h00) time_to_bytes();
                  else if ((diff & ~r.write_data & CTL_W) != 8'h00) bytes_to_time();
               end else begin
                  nvram_bytes[a] = r.write_data;
               end
            end
         end
         OP_LOAD: begin
            rtc_time.year    = 13'(r.load_year);
            rtc_time.month   = 7'(r.load_month) + 7'd1;
            rtc_time.day     = 7'(r.load_day) + 7'd1;
            rtc_time.weekday = 7'(r.load_weekday) + 7'd1;
            rtc_time.hour    = 7'(r.load_hour);
            rtc_time.minute  = 7'(r.load_minute);
            rtc_time.second  = 7'(r.load_second);
            time_to_bytes();
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES_DEF; i++) nvram_bytes[i] = 8'h00;
         rtc_time = RST_TIME;
         time_to_bytes();
         replies_due.delete();
      end else begin
         if (req_valid && req_ready) replies_due.push_back(bus_access_result(req_data));
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               fails++;
               $display("%0t: response with none due: data %h rd %b wr %b", $time,
                        rsp_data.read_data, rsp_data.clock_read_seen,
                        rsp_data.clock_write_seen);
            end else begin
               want = replies_due.pop_front();
               if (rsp_data !== want) begin
                  fails++;
                  $display("%0t: mismatch: expected data %h rd %b wr %b, got data %h rd %b wr %b",
                           $time, want.read_data, want.clock_read_seen, want.clock_write_seen,
                           rsp_data.read_data, rsp_data.clock_read_seen,
                           rsp_data.clock_write_seen);
               end
            end
         end
      end
      replies_owed <= replies_due.size();
      mismatches   <= fails;
   end

endmodule

// File: verif/bcd_rtc_nvram_bus_model_unit_test.sv
// Testbench top for the BCD clock battery RAM: request stimulus, response stalls, verdict.
`timescale 1ns / 100ps

module bcd_rtc_nvram_bus_model_unit_test;

   import bcdrtc_pkg::*;

   localparam int RTC_BASE = STORE_BYTES_DEF - 8;
   localparam int RANDOM_REQUESTS = 1050;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [7:0] CTL_W = 8'h80;
   localparam logic [7:0] CTL_R = 8'h40;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TRICKLE} rx_mode_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      replies_owed;

   int          issued = 0;
   int          burst_left = 0;
   logic [7:0]  century_mirror = 8'h20;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_run = 0;

   bcd_rtc_nvram_bus_model_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   bcd_rtc_nvram_bus_model_unit_check check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .mismatches(mismatches), .replies_owed(replies_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (rx_run == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_run = $urandom_range(8, 60);
      end
      rx_run--;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= (rx_run % 9 == 0);
      endcase
   end

   function automatic req_type any_request();
      req_type r;
      r.opcode       = 2'($urandom_range(0, 3));
      r.address      = 16'($urandom);
      r.write_data   = 8'($urandom);
      r.load_year    = 12'($urandom_range(0, 3999));
      r.load_month   = 4'($urandom_range(0, 11));
      r.load_day     = 5'($urandom_range(0, 30));
      r.load_weekday = 3'($urandom_range(0, 6));
      r.load_hour    = 5'($urandom_range(0, 23));
      r.load_minute  = 6'($urandom_range(0, 59));
      r.load_second  = 6'($urandom_range(0, 59));
      return r;
   endfunction

   function automatic req_type bus_op(input logic [1:0] op, input int addr,
                                      input logic [7:0] d);
      req_type r;
      r = any_request();
      r.opcode = op;
      r.address = 16'(addr);
      r.write_data = d;
      return r;
   endfunction

   function automatic req_type clock_load(input int y, input int mo, input int d,
                                          input int wd, input int h, input int mi,
                                          input int s);
      req_type r;
      r = bus_op(OP_LOAD, $urandom, 8'($urandom));
      r.load_year = 12'(y);
      r.load_month = 4'(mo);
      r.load_day = 5'(d);
      r.load_weekday = 3'(wd);
      r.load_hour = 5'(h);
      r.load_minute = 6'(mi);
      r.load_second = 6'(s);
      return r;
   endfunction

   function automatic logic [7:0] bcd_of(input int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   function automatic int pick_address();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 6) return $urandom_range(0, 63);
      if (sel < 10) return $urandom_range(0, RTC_BASE - 1);
      if (sel < 17) return RTC_BASE + $urandom_range(0, 7);
      return $urandom_range(STORE_BYTES_DEF, 65535);
   endfunction

   // mostly well-formed BCD for the field, sometimes garbage or zero
   function automatic logic [7:0] clock_field_byte(input logic [2:0] ofs);
      logic [7:0] b;
      if ($urandom_range(0, 5) == 0) return 8'($urandom);
      case (ofs)
         OFS_SECOND, OFS_MINUTE: b = bcd_of($urandom_range(0, 59));
         OFS_HOUR:               b = bcd_of($urandom_range(0, 23));
         OFS_WEEKDAY:            b = bcd_of($urandom_range(0, 7));
         OFS_DAY:                b = bcd_of($urandom_range(0, 31));
         OFS_MONTH:              b = bcd_of($urandom_range(0, 12));
         default:                b = bcd_of($urandom_range(0, 99));
      endcase
      return b;
   endfunction

   task automatic issue(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued++;
      if (r.opcode == OP_WRITE && r.address == RTC_BASE) century_mirror = r.write_data;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_owed != 0);
   endtask

   task automatic read_clock_bytes(input int n);
      repeat (n) issue(bus_op(OP_READ, RTC_BASE + $urandom_range(0, 7), 8'($urandom)));
   endtask

   initial begin
      logic [2:0] ofs;
      logic [7:0] ctl;
      req_type    r;
      int         directed;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      issue(bus_op(OP_READ, 0, 8'h00));
      issue(bus_op(OP_WRITE, 0, 8'hff));
      issue(bus_op(OP_READ, 0, 8'h00));
      issue(bus_op(OP_WRITE, RTC_BASE - 1, 8'ha5));
      issue(bus_op(OP_READ, RTC_BASE - 1, 8'h00));
      issue(bus_op(OP_READ, RTC_BASE + OFS_CENTURY, 8'h00));
      issue(bus_op(OP_READ, RTC_BASE + OFS_WEEKDAY, 8'h00));
      issue(bus_op(OP_WRITE, STORE_BYTES_DEF, 8'h3c));
      issue(bus_op(OP_READ, 65535, 8'h00));
      issue(bus_op(OP_NONE, RTC_BASE, 8'h5a));
      issue(clock_load(3999, 11, 30, 6, 23, 59, 59));
      issue(bus_op(OP_READ, RTC_BASE + OFS_HOUR, 8'h00));
      issue(bus_op(OP_READ, RTC_BASE + OFS_CENTURY, 8'h00));
      // W held: raw BCD writes, including bad digits and a zero day, then decoded on release
      issue(bus_op(OP_WRITE, RTC_BASE + OFS_CENTURY, CTL_W | 8'h20));
      issue(bus_op(OP_WRITE, RTC_BASE + OFS_MONTH, 8'h1f));
      issue(bus_op(OP_WRITE, RTC_BASE + OFS_DAY, 8'h00));
      issue(bus_op(OP_WRITE, RTC_BASE + OFS_SECOND, 8'hfa));
      issue(bus_op(OP_WRITE, RTC_BASE + OFS_CENTURY, 8'h20));
      issue(bus_op(OP_READ, RTC_BASE + OFS_MONTH, 8'h00));
      issue(bus_op(OP_READ, RTC_BASE + OFS_SECOND, 8'h00));
      // R held: a load still copies through
      issue(bus_op(OP_WRITE, RTC_BASE + OFS_CENTURY, CTL_R | 8'h20));
      issue(clock_load(0, 0, 0, 0, 0, 0, 0));
      issue(bus_op(OP_READ, RTC_BASE + OFS_DAY, 8'h00));
      issue(bus_op(OP_WRITE, RTC_BASE + OFS_CENTURY, 8'h00));
      issue(bus_op(OP_READ, RTC_BASE + OFS_YEAR, 8'h00));
      directed = issued;
      settle();

      while (issued < directed + RANDOM_REQUESTS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               r = any_request();
               r.address = 16'(pick_address());
               issue(r);
            end
            4, 5, 6: begin
               ctl = century_mirror & CTL_R;
               issue(bus_op(OP_WRITE, RTC_BASE,
                            ctl | CTL_W | bcd_of($urandom_range(0, 39))));
               repeat ($urandom_range(1, 7)) begin
                  ofs = 3'($urandom_range(1, 7));
                  issue(bus_op(OP_WRITE, RTC_BASE + ofs, clock_field_byte(ofs)));
               end
               if ($urandom_range(0, 7) == 0) ctl ^= CTL_R;
               issue(bus_op(OP_WRITE, RTC_BASE, ctl | (century_mirror & 8'h3f)));
               read_clock_bytes($urandom_range(1, 4));
            end
            7: begin
               issue(bus_op(OP_WRITE, RTC_BASE, century_mirror | CTL_R));
               read_clock_bytes($urandom_range(1, 3));
               if ($urandom_range(0, 1) == 0) begin
                  r = any_request();
                  r.opcode = OP_LOAD;
                  issue(r);
               end
               read_clock_bytes($urandom_range(0, 2));
               issue(bus_op(OP_WRITE, RTC_BASE, century_mirror & ~(CTL_R | CTL_W)));
               read_clock_bytes($urandom_range(1, 3));
            end
            8: begin
               r = any_request();
               r.opcode = OP_LOAD;
               issue(r);
               read_clock_bytes($urandom_range(1, 8));
            end
            default: begin
               ofs = 3'($urandom_range(0, 7));
               issue(bus_op(OP_WRITE, $urandom_range(0, 63), 8'($urandom)));
               issue(bus_op(OP_READ, RTC_BASE + ofs, 8'($urandom)));
               issue(bus_op(OP_READ, $urandom_range(0, 63), 8'($urandom)));
            end
         endcase
         if ($urandom_range(0, 120) == 0) settle();
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && replies_owed == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
